[src/sbl_pkg.sv]
// ----------------------------------------------------------------------------
// S-expression byte lexer package
// Token kinds, character codes, lexer modes and the result record shared by
// the lexer core, its step logic and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

  // Token kinds as they appear on the result channel.
  localparam logic [2:0] K_LPAREN = 3'd0;
  localparam logic [2:0] K_RPAREN = 3'd1;
  localparam logic [2:0] K_QUOTE  = 3'd2;
  localparam logic [2:0] K_NUMBER = 3'd3;
  localparam logic [2:0] K_STRING = 3'd4;
  localparam logic [2:0] K_SYMBOL = 3'd5;
  localparam logic [2:0] K_EOF    = 3'd6;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Results an input byte can cause at most.
  localparam int unsigned MAX_RES = 3;

  // Output channel layout.
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_COMMENT = 7'b0000010,
    M_SIGN    = 7'b0000100,
    M_NUMBER  = 7'b0001000,
    M_STRING  = 7'b0010000,
    M_ESCAPE  = 7'b0100000,
    M_SYMBOL  = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  ch;
    logic        ch_valid;
    logic        begins;
    logic        ends;
    logic [31:0] start;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

[src/sbl_step.sv]
// ----------------------------------------------------------------------------
// S-expression lexer step logic
// Combinational update for one text byte or end marker: next lexer state and
// up to three result records with their count.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_step #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic [7:0]               byte_value,
  input  wire logic                     end_of_text,
  input  wire sbl_pkg::mode_t           mode,
  input  wire logic                     sign_minus,
  input  wire logic [POSITION_BITS-1:0] byte_pos,
  input  wire logic [POSITION_BITS-1:0] token_start,
  output sbl_pkg::mode_t                mode_nxt,
  output logic                          sign_minus_nxt,
  output logic [POSITION_BITS-1:0]      byte_pos_nxt,
  output logic [POSITION_BITS-1:0]      token_start_nxt,
  output sbl_pkg::res_t [2:0]           res,
  output logic [1:0]                    res_cnt
);

  logic [31:0] pos32;
  logic [31:0] ts32;
  logic [7:0]  sign_ch;
  logic [7:0]  esc_ch;
  logic        is_sp;
  logic        is_dig;
  logic        sym_stop;
  logic        run_sym;
  logic        run_idle;

  function automatic sbl_pkg::res_t mk(input logic [2:0] k, input logic [7:0] c,
                                       input logic v, input logic bg, input logic e,
                                       input logic [31:0] s);
    sbl_pkg::res_t r;
    r.kind     = k;
    r.ch       = c;
    r.ch_valid = v;
    r.begins   = bg;
    r.ends     = e;
    r.start    = s;
    r.last     = 1'b0;
    return r;
  endfunction

  assign pos32   = 32'(byte_pos);
  assign ts32    = 32'(token_start);
  assign sign_ch = sign_minus ? sbl_pkg::CH_MINUS : sbl_pkg::CH_PLUS;
  assign is_sp   = (byte_value == sbl_pkg::CH_SPACE) ||
                   ((byte_value >= sbl_pkg::CH_TAB) && (byte_value <= sbl_pkg::CH_CR));
  assign is_dig  = (byte_value >= sbl_pkg::CH_ZERO) && (byte_value <= sbl_pkg::CH_NINE);
  assign sym_stop = is_sp || (byte_value == sbl_pkg::CH_LPAREN) ||
                    (byte_value == sbl_pkg::CH_RPAREN) ||
                    (byte_value == sbl_pkg::CH_DQUOTE) || (byte_value == sbl_pkg::CH_SEMI);

  always_comb begin
    priority if (byte_value == sbl_pkg::CH_N) begin
      esc_ch = sbl_pkg::CH_LF;
    end else if (byte_value == sbl_pkg::CH_T) begin
      esc_ch = sbl_pkg::CH_TAB;
    end else if (byte_value == sbl_pkg::CH_R) begin
      esc_ch = sbl_pkg::CH_CR;
    end else begin
      esc_ch = byte_value;
    end
  end

  always_comb begin
    mode_nxt        = mode;
    sign_minus_nxt  = sign_minus;
    token_start_nxt = token_start;
    byte_pos_nxt    = byte_pos;
    res             = '0;
    res_cnt         = 2'd0;
    run_sym         = 1'b0;
    run_idle        = 1'b0;

    if (end_of_text) begin
      // Close whatever is open, then report end of text and start over.
      unique case (mode)
        sbl_pkg::M_NUMBER: begin
          res[res_cnt] = mk(sbl_pkg::K_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
          res_cnt = res_cnt + 2'd1;
        end
        sbl_pkg::M_SYMBOL: begin
          res[res_cnt] = mk(sbl_pkg::K_SYMBOL, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
          res_cnt = res_cnt + 2'd1;
        end
        sbl_pkg::M_STRING: begin
          res[res_cnt] = mk(sbl_pkg::K_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
          res_cnt = res_cnt + 2'd1;
        end
        sbl_pkg::M_ESCAPE: begin
          // A dangling backslash stays in the string as itself.
          res[res_cnt] = mk(sbl_pkg::K_STRING, sbl_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, ts32);
          res_cnt = res_cnt + 2'd1;
          res[res_cnt] = mk(sbl_pkg::K_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
          res_cnt = res_cnt + 2'd1;
        end
        sbl_pkg::M_SIGN: begin
          res[res_cnt] = mk(sbl_pkg::K_SYMBOL, sign_ch, 1'b1, 1'b1, 1'b0, ts32);
          res_cnt = res_cnt + 2'd1;
          res[res_cnt] = mk(sbl_pkg::K_SYMBOL, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
          res_cnt = res_cnt + 2'd1;
        end
        default: begin
        end
      endcase
      res[res_cnt] = mk(sbl_pkg::K_EOF, 8'h00, 1'b0, 1'b1, 1'b1, pos32);
      res_cnt = res_cnt + 2'd1;
      mode_nxt        = sbl_pkg::M_IDLE;
      sign_minus_nxt  = 1'b0;
      byte_pos_nxt    = '0;
      token_start_nxt = '0;
    end else begin
      unique case (mode)
        sbl_pkg::M_COMMENT: begin
          if (byte_value == sbl_pkg::CH_LF) begin
            mode_nxt = sbl_pkg::M_IDLE;
          end
        end
        sbl_pkg::M_SIGN: begin
          res[res_cnt] = mk(is_dig ? sbl_pkg::K_NUMBER : sbl_pkg::K_SYMBOL, sign_ch,
                            1'b1, 1'b1, 1'b0, ts32);
          res_cnt = res_cnt + 2'd1;
          if (is_dig) begin
            res[res_cnt] = mk(sbl_pkg::K_NUMBER, byte_value, 1'b1, 1'b0, 1'b0, ts32);
            res_cnt = res_cnt + 2'd1;
            mode_nxt = sbl_pkg::M_NUMBER;
          end else begin
            run_sym = 1'b1;
          end
        end
        sbl_pkg::M_NUMBER: begin
          if (is_dig || (byte_value == sbl_pkg::CH_DOT)) begin
            res[res_cnt] = mk(sbl_pkg::K_NUMBER, byte_value, 1'b1, 1'b0, 1'b0, ts32);
            res_cnt = res_cnt + 2'd1;
          end else begin
            res[res_cnt] = mk(sbl_pkg::K_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
            res_cnt = res_cnt + 2'd1;
            run_idle = 1'b1;
          end
        end
        sbl_pkg::M_SYMBOL: begin
          run_sym = 1'b1;
        end
        sbl_pkg::M_STRING: begin
          priority if (byte_value == sbl_pkg::CH_DQUOTE) begin
            res[res_cnt] = mk(sbl_pkg::K_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
            res_cnt = res_cnt + 2'd1;
            mode_nxt = sbl_pkg::M_IDLE;
          end else if (byte_value == sbl_pkg::CH_BSLASH) begin
            mode_nxt = sbl_pkg::M_ESCAPE;
          end else begin
            res[res_cnt] = mk(sbl_pkg::K_STRING, byte_value, 1'b1, 1'b0, 1'b0, ts32);
            res_cnt = res_cnt + 2'd1;
          end
        end
        sbl_pkg::M_ESCAPE: begin
          res[res_cnt] = mk(sbl_pkg::K_STRING, esc_ch, 1'b1, 1'b0, 1'b0, ts32);
          res_cnt = res_cnt + 2'd1;
          mode_nxt = sbl_pkg::M_STRING;
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      // Symbol continuation; a delimiter closes it and is lexed afresh.
      if (run_sym) begin
        if (sym_stop) begin
          res[res_cnt] = mk(sbl_pkg::K_SYMBOL, 8'h00, 1'b0, 1'b0, 1'b1, ts32);
          res_cnt = res_cnt + 2'd1;
          run_idle = 1'b1;
        end else begin
          res[res_cnt] = mk(sbl_pkg::K_SYMBOL, byte_value, 1'b1, 1'b0, 1'b0, ts32);
          res_cnt = res_cnt + 2'd1;
          mode_nxt = sbl_pkg::M_SYMBOL;
        end
      end

      // Between tokens: skip blanks, enter comments, or open a token here.
      if (run_idle) begin
        mode_nxt = sbl_pkg::M_IDLE;
        if (is_sp) begin
        end else if (byte_value == sbl_pkg::CH_SEMI) begin
          mode_nxt = sbl_pkg::M_COMMENT;
        end else begin
          token_start_nxt = byte_pos;
          priority if (byte_value == sbl_pkg::CH_LPAREN) begin
            res[res_cnt] = mk(sbl_pkg::K_LPAREN, byte_value, 1'b1, 1'b1, 1'b1, pos32);
            res_cnt = res_cnt + 2'd1;
          end else if (byte_value == sbl_pkg::CH_RPAREN) begin
            res[res_cnt] = mk(sbl_pkg::K_RPAREN, byte_value, 1'b1, 1'b1, 1'b1, pos32);
            res_cnt = res_cnt + 2'd1;
          end else if (byte_value == sbl_pkg::CH_QUOTE) begin
            res[res_cnt] = mk(sbl_pkg::K_QUOTE, byte_value, 1'b1, 1'b1, 1'b1, pos32);
            res_cnt = res_cnt + 2'd1;
          end else if (byte_value == sbl_pkg::CH_DQUOTE) begin
            res[res_cnt] = mk(sbl_pkg::K_STRING, 8'h00, 1'b0, 1'b1, 1'b0, pos32);
            res_cnt = res_cnt + 2'd1;
            mode_nxt = sbl_pkg::M_STRING;
          end else if (is_dig) begin
            res[res_cnt] = mk(sbl_pkg::K_NUMBER, byte_value, 1'b1, 1'b1, 1'b0, pos32);
            res_cnt = res_cnt + 2'd1;
            mode_nxt = sbl_pkg::M_NUMBER;
          end else if ((byte_value == sbl_pkg::CH_MINUS) ||
                       (byte_value == sbl_pkg::CH_PLUS)) begin
            sign_minus_nxt = (byte_value == sbl_pkg::CH_MINUS);
            mode_nxt = sbl_pkg::M_SIGN;
          end else begin
            res[res_cnt] = mk(sbl_pkg::K_SYMBOL, byte_value, 1'b1, 1'b1, 1'b0, pos32);
            res_cnt = res_cnt + 2'd1;
            mode_nxt = sbl_pkg::M_SYMBOL;
          end
        end
      end

      // The position counter sticks at its top value.
      if (byte_pos != '1) begin
        byte_pos_nxt = byte_pos + POSITION_BITS'(1);
      end
    end

    if (res_cnt != 2'd0) begin
      res[res_cnt - 2'd1].last = 1'b1;
    end
  end

endmodule

`default_nettype wire

[src/sexpr_byte_lexer_core.sv]
// A byte waits in the input register until the result queue has room; its results are
// registered in the queue. Throughput: one byte per cycle while each byte causes at most
// one result and the output takes results; a byte with two or three results holds the
// input until the queue drains, as the four-entry queue needs room for three per byte.
// Reset: synchronous, active low; lexer state, position and the queue clear at once.
// ----------------------------------------------------------------------------
// S-expression byte lexer core
// Streams text bytes in and tagged token characters out, with token framing
// and start positions.
// ----------------------------------------------------------------------------
`default_nettype none

module sexpr_byte_lexer_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input requests: one text byte or an end marker.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // end_of_text
  // Result requests.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] char_value, [8] char_valid,
                                       // [9] token_begins, [10] token_ends,
                                       // [42:11] start_position, [47:43] zero
  output logic [2:0]       out_tuser,  // [2:0] token_kind
  output logic             out_tlast   // last_result
);

  // --------------------------------------------------------------------------
  // Input register. A request is captured here and lexed once the result
  // queue has room for the largest burst a byte can cause.
  // --------------------------------------------------------------------------
  logic                     in_v_r, in_v_nxt;
  logic [7:0]               in_byte_r;
  logic                     in_eot_r;
  logic                     proc;

  // Lexer state.
  sbl_pkg::mode_t           mode_r, mode_nxt;
  logic                     sign_r, sign_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] ts_r, ts_nxt;

  // Results of the byte being lexed.
  sbl_pkg::res_t [2:0]      step_res;
  logic [1:0]               step_cnt;

  // Result queue: four entries, head entry drives the output.
  sbl_pkg::res_t            q_r [4];
  logic [1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [2:0]               cnt_r, cnt_nxt;
  logic                     pop;
  logic [2:0]               push_n;
  sbl_pkg::res_t            head;

  // The queue must hold three free entries before a byte is lexed; a pop in the
  // same cycle is not counted so that the output ready does not reach the input.
  assign proc      = in_v_r && (cnt_r <= 3'd1);
  assign in_tready = !in_v_r || proc;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (proc) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  sbl_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .byte_value      (in_byte_r),
    .end_of_text     (in_eot_r),
    .mode            (mode_r),
    .sign_minus      (sign_r),
    .byte_pos        (pos_r),
    .token_start     (ts_r),
    .mode_nxt        (mode_nxt),
    .sign_minus_nxt  (sign_nxt),
    .byte_pos_nxt    (pos_nxt),
    .token_start_nxt (ts_nxt),
    .res             (step_res),
    .res_cnt         (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sbl_pkg::M_IDLE;
      sign_r <= 1'b0;
      pos_r  <= '0;
      ts_r   <= '0;
    end else if (proc) begin
      mode_r <= mode_nxt;
      sign_r <= sign_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue.
  // --------------------------------------------------------------------------
  assign pop        = out_tvalid && out_tready;
  assign push_n     = proc ? {1'b0, step_cnt} : 3'd0;
  assign wr_ptr_nxt = wr_ptr_r + push_n[1:0];
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign cnt_nxt    = cnt_r + push_n - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (3'(i) < push_n) begin
        q_r[wr_ptr_r + 2'(i)] <= step_res[i];
      end
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {5'd0, head.start, head.ends, head.begins, head.ch_valid, head.ch};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule

`default_nettype wire

[src/sbl_checker.sv]
// ----------------------------------------------------------------------------
// S-expression lexer port checker
// Watches the result channel of the lexer core and flags framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // Nothing is offered in the cycle after a reset.
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A result that is offered stays offered until it is taken.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  // End of text is always the final result of its byte and is a bare marker.
  a_eof_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sbl_pkg::K_EOF) |->
      out_tlast && out_tdata[9] && out_tdata[10] && !out_tdata[8])
    else $error("malformed end of text result");

  // A token that opens and closes in one result is a paren, a quote or end of text.
  a_single_result_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] && out_tdata[10] |->
      (out_tuser == sbl_pkg::K_LPAREN) || (out_tuser == sbl_pkg::K_RPAREN) ||
      (out_tuser == sbl_pkg::K_QUOTE) || (out_tuser == sbl_pkg::K_EOF))
    else $error("multi-character token framed as one result");

endmodule

bind sexpr_byte_lexer_core sbl_checker u_sbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/sv/sbl_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Byte lexer scoreboard
// Predicts the token characters that the byte lexer gives for each accepted
// text byte or end marker, and checks the results against them in order.
// ----------------------------------------------------------------------------
package sbl_tb_pkg;

  function automatic bit is_blank(logic [7:0] b);
    return b == sbl_pkg::CH_SPACE || (b >= sbl_pkg::CH_TAB && b <= sbl_pkg::CH_CR);
  endfunction

  // Bytes that close a symbol and are then lexed afresh.
  function automatic bit is_symbol_break(logic [7:0] b);
    return is_blank(b) || b == sbl_pkg::CH_LPAREN || b == sbl_pkg::CH_RPAREN ||
           b == sbl_pkg::CH_DQUOTE || b == sbl_pkg::CH_SEMI;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= sbl_pkg::CH_ZERO && b <= sbl_pkg::CH_NINE;
  endfunction

  class token_scoreboard #(int unsigned POS_W = 32);
    typedef logic [POS_W-1:0] pos_t;

    sbl_pkg::mode_t mode;
    bit             held_minus;
    pos_t           position;
    pos_t           tok_start;
    sbl_pkg::res_t  token_chars_q[$];
    sbl_pkg::res_t  step_q[$];
    int unsigned    failures;

    function new();
      clear_state();
      failures = 0;
    endfunction

    function void clear_state();
      mode       = sbl_pkg::M_IDLE;
      held_minus = 1'b0;
      position   = '0;
      tok_start  = '0;
    endfunction

    function bit at_top();
      return &position;
    endfunction

    function int unsigned pending();
      return token_chars_q.size();
    endfunction

    function void put(logic [2:0] kind, logic [7:0] ch, bit vld, bit beg, bit fin, pos_t at);
      sbl_pkg::res_t r;
      if (step_q.size() >= sbl_pkg::MAX_RES) return;
      r.kind     = kind;
      r.ch       = ch;
      r.ch_valid = vld;
      r.begins   = beg;
      r.ends     = fin;
      r.start    = 32'(at);
      r.last     = 1'b0;
      step_q = {step_q, r};
    endfunction

    // A byte seen between tokens.
    function void start_token(logic [7:0] b);
      if (is_blank(b)) return;
      if (b == sbl_pkg::CH_SEMI) begin
        mode = sbl_pkg::M_COMMENT;
        return;
      end
      tok_start = position;
      if (b == sbl_pkg::CH_LPAREN) begin
        put(sbl_pkg::K_LPAREN, b, 1, 1, 1, position);
      end else if (b == sbl_pkg::CH_RPAREN) begin
        put(sbl_pkg::K_RPAREN, b, 1, 1, 1, position);
      end else if (b == sbl_pkg::CH_QUOTE) begin
        put(sbl_pkg::K_QUOTE, b, 1, 1, 1, position);
      end else if (b == sbl_pkg::CH_DQUOTE) begin
        put(sbl_pkg::K_STRING, 8'h00, 0, 1, 0, position);
        mode = sbl_pkg::M_STRING;
      end else if (is_digit(b)) begin
        put(sbl_pkg::K_NUMBER, b, 1, 1, 0, position);
        mode = sbl_pkg::M_NUMBER;
      end else if (b == sbl_pkg::CH_MINUS || b == sbl_pkg::CH_PLUS) begin
        held_minus = (b == sbl_pkg::CH_MINUS);
        mode = sbl_pkg::M_SIGN;
      end else begin
        put(sbl_pkg::K_SYMBOL, b, 1, 1, 0, position);
        mode = sbl_pkg::M_SYMBOL;
      end
    endfunction

    function void symbol_next(logic [7:0] b);
      if (is_symbol_break(b)) begin
        put(sbl_pkg::K_SYMBOL, 8'h00, 0, 0, 1, tok_start);
        mode = sbl_pkg::M_IDLE;
        start_token(b);
      end else begin
        put(sbl_pkg::K_SYMBOL, b, 1, 0, 0, tok_start);
      end
    endfunction

    // Works out the results of one accepted request; returns how many.
    function int unsigned note_request(logic [7:0] b, bit eot);
      logic [7:0] sign_ch;
      logic [7:0] decoded;
      sign_ch = held_minus ? sbl_pkg::CH_MINUS : sbl_pkg::CH_PLUS;
      step_q.delete();
      if (eot) begin
        case (mode)
          sbl_pkg::M_NUMBER: put(sbl_pkg::K_NUMBER, 8'h00, 0, 0, 1, tok_start);
          sbl_pkg::M_SYMBOL: put(sbl_pkg::K_SYMBOL, 8'h00, 0, 0, 1, tok_start);
          sbl_pkg::M_STRING: put(sbl_pkg::K_STRING, 8'h00, 0, 0, 1, tok_start);
          sbl_pkg::M_ESCAPE: begin
            put(sbl_pkg::K_STRING, sbl_pkg::CH_BSLASH, 1, 0, 0, tok_start);
            put(sbl_pkg::K_STRING, 8'h00, 0, 0, 1, tok_start);
          end
          sbl_pkg::M_SIGN: begin
            put(sbl_pkg::K_SYMBOL, sign_ch, 1, 1, 0, tok_start);
            put(sbl_pkg::K_SYMBOL, 8'h00, 0, 0, 1, tok_start);
          end
          default: ;
        endcase
        put(sbl_pkg::K_EOF, 8'h00, 0, 1, 1, position);
        clear_state();
      end else begin
        case (mode)
          sbl_pkg::M_COMMENT: if (b == sbl_pkg::CH_LF) mode = sbl_pkg::M_IDLE;
          sbl_pkg::M_SIGN: begin
            if (is_digit(b)) begin
              put(sbl_pkg::K_NUMBER, sign_ch, 1, 1, 0, tok_start);
              put(sbl_pkg::K_NUMBER, b, 1, 0, 0, tok_start);
              mode = sbl_pkg::M_NUMBER;
            end else begin
              put(sbl_pkg::K_SYMBOL, sign_ch, 1, 1, 0, tok_start);
              mode = sbl_pkg::M_SYMBOL;
              symbol_next(b);
            end
          end
          sbl_pkg::M_NUMBER: begin
            if (is_digit(b) || b == sbl_pkg::CH_DOT) begin
              put(sbl_pkg::K_NUMBER, b, 1, 0, 0, tok_start);
            end else begin
              put(sbl_pkg::K_NUMBER, 8'h00, 0, 0, 1, tok_start);
              mode = sbl_pkg::M_IDLE;
              start_token(b);
            end
          end
          sbl_pkg::M_SYMBOL: symbol_next(b);
          sbl_pkg::M_STRING: begin
            if (b == sbl_pkg::CH_DQUOTE) begin
              put(sbl_pkg::K_STRING, 8'h00, 0, 0, 1, tok_start);
              mode = sbl_pkg::M_IDLE;
            end else if (b == sbl_pkg::CH_BSLASH) begin
              mode = sbl_pkg::M_ESCAPE;
            end else begin
              put(sbl_pkg::K_STRING, b, 1, 0, 0, tok_start);
            end
          end
          sbl_pkg::M_ESCAPE: begin
            decoded = b;
            if (b == sbl_pkg::CH_N) decoded = sbl_pkg::CH_LF;
            else if (b == sbl_pkg::CH_T) decoded = sbl_pkg::CH_TAB;
            else if (b == sbl_pkg::CH_R) decoded = sbl_pkg::CH_CR;
            put(sbl_pkg::K_STRING, decoded, 1, 0, 0, tok_start);
            mode = sbl_pkg::M_STRING;
          end
          default: begin
            mode = sbl_pkg::M_IDLE;
            start_token(b);
          end
        endcase
        if (!at_top()) position = position + 1'b1;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      token_chars_q = {token_chars_q, step_q};
      return step_q.size();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(sbl_pkg::res_t got);
      sbl_pkg::res_t want;
      if (token_chars_q.size() == 0) begin
        $error("result with none expected: kind %0d char %0h", got.kind, got.ch);
        failures++;
        return;
      end
      want = token_chars_q.pop_front();
      check_field("token_kind", want.kind, got.kind);
      check_field("char_value", want.ch, got.ch);
      check_field("char_valid", want.ch_valid, got.ch_valid);
      check_field("token_begins", want.begins, got.begins);
      check_field("token_ends", want.ends, got.ends);
      check_field("start_position", want.start, got.start);
      check_field("last_result", want.last, got.last);
    endfunction
  endclass

endpackage

[tb/sv/sexpr_byte_lexer_core_tb.sv]
// ----------------------------------------------------------------------------
// Byte lexer core testbench
// Feeds directed and random s-expression text into the lexer under random
// input gaps and output back-pressure, and checks every token character it
// gives against a scoreboard that predicts them in order.
// ----------------------------------------------------------------------------
module sexpr_byte_lexer_core_tb;

  // A narrow position counter checks that start positions are widened with zeros.
  localparam int unsigned POS_W = 8;
  // Far beyond the slowest correct run, even with every long stall.
  localparam int unsigned RUN_LIMIT = 5_000_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  sbl_tb_pkg::token_scoreboard #(POS_W) board = new();

  // Accepted input requests so far, blanks and comment text included.
  int unsigned sent_items = 0;
  // While set, the sender offers requests back to back.
  bit          tx_burst   = 1'b0;

  sexpr_byte_lexer_core #(
    .POSITION_BITS (POS_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset is held low from the start and released once.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? sbl_pkg::CH_SPACE :
                                         sbl_pkg::CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  // Offers one request and returns at the edge where it is taken. Must be
  // entered right after a rising edge. With no gap, tvalid simply stays high
  // and only the data changes, so it is never dropped and raised in one step.
  task automatic send_request(input logic [7:0] b, input bit eot);
    int unsigned gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(board.note_request(b, eot));
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // One random lexeme, mostly well formed, followed by an optional blank.
  // Strings are sometimes left open or end on a bare backslash so that a
  // later end marker finds them unfinished.
  task automatic send_lexeme(input bit allow_end);
    int unsigned roll;
    int unsigned n;
    logic [7:0]  b;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      send_request(sbl_pkg::CH_LPAREN, 1'b0);
    end else if (roll < 20) begin
      send_request(sbl_pkg::CH_RPAREN, 1'b0);
    end else if (roll < 25) begin
      send_request(sbl_pkg::CH_QUOTE, 1'b0);
    end else if (roll < 40) begin
      if ($urandom_range(0, 2) == 0) begin
        send_request(($urandom_range(0, 1) == 0) ? sbl_pkg::CH_MINUS : sbl_pkg::CH_PLUS, 1'b0);
      end
      n = $urandom_range(1, 5);
      repeat (n) begin
        b = ($urandom_range(0, 6) == 0) ? sbl_pkg::CH_DOT :
                                          sbl_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        send_request(b, 1'b0);
      end
    end else if (roll < 55) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        do b = 8'($urandom_range(0, 255));
        while (sbl_tb_pkg::is_symbol_break(b));
        send_request(b, 1'b0);
      end
    end else if (roll < 65) begin
      send_request(sbl_pkg::CH_DQUOTE, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          send_request(sbl_pkg::CH_BSLASH, 1'b0);
          case ($urandom_range(0, 3))
            0: b = sbl_pkg::CH_N;
            1: b = sbl_pkg::CH_T;
            2: b = sbl_pkg::CH_R;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_request(b, 1'b0);
        end else begin
          send_request(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      if ($urandom_range(0, 5) != 0) send_request(sbl_pkg::CH_DQUOTE, 1'b0);
      else if ($urandom_range(0, 1) == 0) send_request(sbl_pkg::CH_BSLASH, 1'b0);
    end else if (roll < 72) begin
      send_request(sbl_pkg::CH_SEMI, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == sbl_pkg::CH_LF) b = sbl_pkg::CH_SPACE;
        send_request(b, 1'b0);
      end
      send_request(sbl_pkg::CH_LF, 1'b0);
    end else if (roll < 80) begin
      send_request(blank_char(), 1'b0);
    end else if (roll < 92) begin
      send_request(8'($urandom_range(0, 255)), 1'b0);
    end else if (roll < 96) begin
      send_request(($urandom_range(0, 1) == 0) ? sbl_pkg::CH_MINUS : sbl_pkg::CH_PLUS, 1'b0);
    end else if (allow_end) begin
      // The byte lane carries noise that the lexer must ignore.
      send_request(8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(0, 9) < 6) send_request(blank_char(), 1'b0);
  endtask

  // Stimulus: a short directed text, then random text, then the drain and
  // the verdict.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // End marker with nothing open: EOF alone, at position zero.
    send_request(8'h00, 1'b1);
    // Paren, signed number with a dot, a number closed by a held sign, and
    // that sign turned into a one-character symbol by the end marker.
    send_text("(-1.+");
    send_request(8'h00, 1'b1);
    // Two comments in a row must not leave an empty symbol behind. Then a
    // quote, a number cut short by a letter, and a NUL kept inside a symbol.
    send_text(";\n;x\n'9a");
    send_request(8'h00, 1'b0);
    // A paren closes the symbol; a string with decoded escapes is left with
    // a pending backslash, which the end marker keeps as a literal.
    send_text(")\"\\n\\r\\");
    send_request(8'h00, 1'b1);

    // Many short texts, closed by end markers in every lexer state but the comment state.
    while (sent_items < 170) send_lexeme(1'b1);
    send_request(8'($urandom_range(0, 255)), 1'b1);
    in_tvalid <= 1'b0;

    // Wait until every expected result is taken; spare cycles after that
    // show up any result that was not expected.
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver. Random stalls, with stretches of none, and one long hold-off
  // early in the random text so the result queue fills up and the lexer
  // has to stall its input.
  initial begin : rx_side
    int unsigned hold;
    bit          rx_burst;
    bit          squeeze_done;
    rx_burst     = 1'b0;
    squeeze_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (!squeeze_done && sent_items >= 40) begin
        squeeze_done = 1'b1;
        hold = 120;
      end else begin
        hold = pick_gap(rx_burst);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Every result request taken at an edge is checked against the oldest
  // expected token character. The concatenation follows the field order of
  // the result record.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(sbl_pkg::res_t'({out_tuser, out_tdata[7:0], out_tdata[8],
                                          out_tdata[9], out_tdata[10], out_tdata[42:11],
                                          out_tlast}));
    end
  end

  // A hang, or results that never arrive, end the run here.
  initial begin
    #(RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
